>>> hw/rtl/csd_pkg.sv
// Shared types and constants for the CSR sparse times dense multiplier.
// Used by the MAC datapath and the top level.
package csd_pkg;

  localparam int DEF_MAX_DIM      = 256;
  localparam int DEF_MAX_NNZ      = 1024;
  localparam int DEF_MAX_RHS_COLS = 8;
  localparam int DEF_FRAC_BITS    = 12;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 40;
  localparam int VAL_W     = 16;

  typedef enum logic [2:0] {
    CMD_ROW_START = 3'd0,
    CMD_ENTRY     = 3'd1,
    CMD_DENSE     = 3'd2,
    CMD_COMPUTE   = 3'd3,
    CMD_READ      = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_MODE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_PLAIN   = 2'd0,
    OP_TRANS   = 2'd1,
    OP_CONJ    = 2'd2,
    OP_INVALID = 2'd3
  } op_mode_t;

  typedef enum logic [1:0] {
    REG_OP_MODE     = 2'd0,
    REG_MATRIX_ROWS = 2'd1,
    REG_MATRIX_COLS = 2'd2,
    REG_RHS_COLS    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [2:0]               command;
    logic [9:0]               slot;
    logic [10:0]              pointer_value;
    logic [7:0]               column;
    logic signed [VAL_W-1:0]  value_re;
    logic signed [VAL_W-1:0]  value_im;
  } req_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               saturated;
  } rsp_item_t;

endpackage

>>> hw/rtl/csd_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
// Item type is set by the instantiating level from csd_pkg.
interface csd_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> hw/rtl/csd_mac.sv
// Complex multiply-accumulate datapath: products, floor shift, saturating add.
// Depends on csd_pkg. Two register stages, products then shifted sums; the saturating add is combinational.
module csd_mac #(
  parameter int FRAC_BITS = csd_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic [2*csd_pkg::VAL_W-1:0]       a_val,
  input  logic [2*csd_pkg::VAL_W-1:0]       b_val,
  input  logic                              conj,
  input  logic [2*csd_pkg::ACC_W-1:0]       acc,
  output logic [2*csd_pkg::ACC_W-1:0]       sum
);
  import csd_pkg::*;

  localparam logic signed [ACC_W:0] ACC_HI = 41'sd549755813887;
  localparam logic signed [ACC_W:0] ACC_LO = -41'sd549755813888;

  logic signed [16:0] ar, ai, br, bi;
  logic signed [33:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [34:0] s_re, s_im;
  logic signed [34:0] d_re, d_im;
  logic [2*ACC_W-1:0] acc1, acc2;
  logic signed [ACC_W:0] t_re, t_im;
  logic signed [ACC_W-1:0] o_re, o_im;

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ACC_HI) r = ACC_HI[ACC_W-1:0];
    else if (v < ACC_LO) r = ACC_LO[ACC_W-1:0];
    else r = v[ACC_W-1:0];
    return r;
  endfunction

  always_comb begin
    ar = {a_val[VAL_W-1], a_val[VAL_W-1:0]};
    ai = conj ? -{a_val[2*VAL_W-1], a_val[2*VAL_W-1:VAL_W]}
              : {a_val[2*VAL_W-1], a_val[2*VAL_W-1:VAL_W]};
    br = {b_val[VAL_W-1], b_val[VAL_W-1:0]};
    bi = {b_val[2*VAL_W-1], b_val[2*VAL_W-1:VAL_W]};
    s_re = 35'(p_rr) - 35'(p_ii);
    s_im = 35'(p_ri) + 35'(p_ir);
    t_re = $signed(acc2[ACC_W-1:0]) + 41'(d_re);
    t_im = $signed(acc2[2*ACC_W-1:ACC_W]) + 41'(d_im);
    o_re = sat40(t_re);
    o_im = sat40(t_im);
    sum  = {o_im, o_re};
  end

  always_ff @(posedge clk) begin
    p_rr <= ar * br;
    p_ii <= ai * bi;
    p_ri <= ar * bi;
    p_ir <= ai * br;
    acc1 <= acc;
    d_re <= s_re >>> FRAC_BITS;
    d_im <= s_im >>> FRAC_BITS;
    acc2 <= acc1;
  end
endmodule

>>> hw/rtl/csr_sparse_dense_multiply.sv
// CSR sparse times dense complex multiplier, Q3.12 data, 40-bit accumulators.
// Depends on csd_pkg, csd_stream_if and csd_mac.
// Loads are taken one item per cycle while the response side keeps up; a read answers from
// a separate read state. A compute first clears the result store, then for each right-hand
// column reads each row's start and end from the row-start table and walks its stored
// entries, flagging a range error for one whose column lies outside the matrix; the tables
// and stores are synchronous memories. After reset the same clearing pass runs
// before the first item is taken; configuration writes are accepted throughout.
module csr_sparse_dense_multiply #(
  parameter int MAX_DIM      = csd_pkg::DEF_MAX_DIM,
  parameter int MAX_NNZ      = csd_pkg::DEF_MAX_NNZ,
  parameter int MAX_RHS_COLS = csd_pkg::DEF_MAX_RHS_COLS,
  parameter int FRAC_BITS    = csd_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [csd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csd_pkg::CFG_W-1:0]     cfg_data,
  csd_stream_if.sink                    req,
  csd_stream_if.source                  rsp
);
  import csd_pkg::*;

  localparam int ST_D   = MAX_DIM * MAX_RHS_COLS;
  localparam int ST_W   = $clog2(ST_D);
  localparam int RS_W   = $clog2(MAX_DIM + 1);
  localparam int PTR_W  = $clog2(MAX_NNZ + 1);
  localparam int NNZ_W  = $clog2(MAX_NNZ);
  localparam int OC_W   = $clog2(MAX_RHS_COLS + 1);
  localparam int ENT_W  = 8 + 2*VAL_W;
  localparam int RES_W  = 2*ACC_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ROW0, S_ROW1, S_ROW2,
    S_ENT0, S_ENT1, S_ENT2, S_ENT3, S_ENT4
  } state_t;

  state_t state;

  logic [1:0] op_mode;
  logic [8:0] matrix_rows, matrix_cols;
  logic [3:0] rhs_cols;

  logic [PTR_W-1:0] rs_mem [MAX_DIM+1];
  logic [ENT_W-1:0] ent_mem [MAX_NNZ];
  logic [2*VAL_W-1:0] dn_mem [ST_D];
  logic [RES_W-1:0] res_mem [ST_D];

  logic [PTR_W-1:0] rs_q;
  logic [ENT_W-1:0] ent_q;
  logic [2*VAL_W-1:0] dn_q;
  logic [RES_W-1:0] res_q;

  logic rs_we, rs_re, ent_we, ent_re, dn_we, dn_re, res_we, res_re;
  logic [RS_W-1:0] rs_waddr, rs_raddr;
  logic [NNZ_W-1:0] ent_waddr, ent_raddr;
  logic [ST_W-1:0] dn_raddr, res_waddr, res_raddr, ld_addr, tgt_addr;
  logic [RES_W-1:0] res_wdata, mac_sum;

  logic [ST_W-1:0] clr_addr, res_addr, o_base;
  logic clr_compute, trans, conj, bad;
  logic [RS_W-1:0] row_i;
  logic [OC_W-1:0] o_cnt;
  logic [PTR_W-1:0] row_s, row_e, row_j;

  logic o_valid;
  rsp_item_t o_item;

  logic accept, col_bad, last_ent, row_done;
  command_t cmd;
  logic [31:0] slot32, ptr32, col32, rows_lim, cols_lim, n_lim;
  logic rs_bad, ent_bad, dn_bad;
  logic [7:0] ent_col;

  function automatic logic signed [31:0] clip32(input logic signed [ACC_W-1:0] v,
                                                output logic f);
    logic signed [31:0] r;
    f = 1'b0;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
      f = 1'b1;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
      f = 1'b1;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign req.ready = (state == S_IDLE) && (!o_valid || rsp.ready);
  assign rsp.valid = o_valid;
  assign rsp.item  = o_item;

  always_comb begin
    accept   = req.valid && req.ready;
    cmd      = command_t'(req.item.command);
    slot32   = 32'(req.item.slot);
    ptr32    = 32'(req.item.pointer_value);
    col32    = 32'(req.item.column);
    rs_bad   = slot32 > 32'(MAX_DIM) || ptr32 > 32'(MAX_NNZ);
    ent_bad  = slot32 >= 32'(MAX_NNZ);
    dn_bad   = slot32 >= 32'(MAX_DIM) || col32 >= 32'(MAX_RHS_COLS);
    ld_addr  = ST_W'(col32 * 32'(MAX_DIM) + slot32);
    rows_lim = 32'(matrix_rows) > 32'(MAX_DIM) ? 32'(MAX_DIM) : 32'(matrix_rows);
    cols_lim = 32'(matrix_cols) > 32'(MAX_DIM) ? 32'(MAX_DIM) : 32'(matrix_cols);
    n_lim    = 32'(rhs_cols) > 32'(MAX_RHS_COLS) ? 32'(MAX_RHS_COLS) : 32'(rhs_cols);
    ent_col  = ent_q[ENT_W-1 -: 8];
    col_bad  = 32'(ent_col) >= cols_lim;
    last_ent = ({1'b0, row_j} + 1'b1) >= {1'b0, row_e};
    row_done = (state == S_ROW2 && rs_q <= row_s) ||
               (((state == S_ENT1 && col_bad) || state == S_ENT4) && last_ent);
    tgt_addr = trans ? o_base + ST_W'(ent_col) : o_base + ST_W'(row_i);

    rs_we     = accept && cmd == CMD_ROW_START && !rs_bad;
    rs_waddr  = RS_W'(slot32);
    rs_re     = state == S_ROW0 || state == S_ROW1;
    rs_raddr  = state == S_ROW0 ? row_i : row_i + 1'b1;
    ent_we    = accept && cmd == CMD_ENTRY && !ent_bad;
    ent_waddr = NNZ_W'(slot32);
    ent_re    = state == S_ENT0;
    ent_raddr = row_j[NNZ_W-1:0];
    dn_we     = accept && cmd == CMD_DENSE && !dn_bad;
    dn_re     = state == S_ENT1 && !col_bad;
    dn_raddr  = trans ? o_base + ST_W'(row_i) : o_base + ST_W'(ent_col);
    res_we    = state == S_CLEAR || state == S_ENT4;
    res_waddr = state == S_CLEAR ? clr_addr : res_addr;
    res_wdata = state == S_CLEAR ? '0 : mac_sum;
    res_re    = (accept && cmd == CMD_READ && !dn_bad) || (state == S_ENT1 && !col_bad);
    res_raddr = state == S_IDLE ? ld_addr : tgt_addr;
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_waddr] <= PTR_W'(ptr32);
    if (rs_re) rs_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= {req.item.column, req.item.value_im, req.item.value_re};
    if (ent_re) ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (dn_we) dn_mem[ld_addr] <= {req.item.value_im, req.item.value_re};
    if (dn_re) dn_q <= dn_mem[dn_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (res_re) res_q <= res_mem[res_raddr];
  end

  csd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk   (clk),
    .a_val (ent_q[2*VAL_W-1:0]),
    .b_val (dn_q),
    .conj  (conj),
    .acc   (res_q),
    .sum   (mac_sum)
  );

  always_ff @(posedge clk) begin
    logic f_re, f_im;
    logic signed [31:0] c_re, c_im;
    status_t item_st;
    c_re = clip32($signed(res_q[ACC_W-1:0]), f_re);
    c_im = clip32($signed(res_q[RES_W-1:ACC_W]), f_im);
    item_st = STATUS_OK;
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_compute <= 1'b0;
      o_valid     <= 1'b0;
      op_mode     <= OP_PLAIN;
      matrix_rows <= 9'd1;
      matrix_cols <= 9'd1;
      rhs_cols    <= 4'd1;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_OP_MODE:     op_mode     <= cfg_data[1:0];
          REG_MATRIX_ROWS: matrix_rows <= cfg_data[8:0];
          REG_MATRIX_COLS: matrix_cols <= cfg_data[8:0];
          REG_RHS_COLS:    rhs_cols    <= cfg_data[3:0];
        endcase
      end
      if (rsp.valid && rsp.ready) o_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          if (clr_addr == ST_W'(ST_D - 1)) begin
            clr_addr <= '0;
            if (clr_compute) begin
              if (rows_lim == 32'd0 || n_lim == 32'd0) begin
                o_valid <= 1'b1;
                o_item  <= '{status: STATUS_OK, result_re: '0, result_im: '0,
                             saturated: 1'b0};
                state   <= S_IDLE;
              end else begin
                row_i  <= '0;
                o_cnt  <= '0;
                o_base <= '0;
                state  <= S_ROW0;
              end
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            o_valid <= 1'b1;
            priority case (cmd)
              CMD_ROW_START: if (rs_bad) item_st = STATUS_RANGE;
              CMD_ENTRY:     if (ent_bad) item_st = STATUS_RANGE;
              CMD_DENSE:     if (dn_bad) item_st = STATUS_RANGE;
              CMD_COMPUTE: begin
                if (op_mode == OP_INVALID) begin
                  item_st = STATUS_MODE;
                end else begin
                  o_valid     <= 1'b0;
                  trans       <= op_mode != OP_PLAIN;
                  conj        <= op_mode == OP_CONJ;
                  bad         <= 1'b0;
                  clr_compute <= 1'b1;
                  clr_addr    <= '0;
                  state       <= S_CLEAR;
                end
              end
              CMD_READ: begin
                if (dn_bad) begin
                  item_st = STATUS_RANGE;
                end else begin
                  o_valid <= 1'b0;
                  state   <= S_READ;
                end
              end
              default: item_st = STATUS_RANGE;
            endcase
            o_item <= '{status: item_st, result_re: '0, result_im: '0, saturated: 1'b0};
          end
        end
        S_READ: begin
          o_valid <= 1'b1;
          o_item  <= '{status: STATUS_OK, result_re: c_re, result_im: c_im,
                       saturated: f_re | f_im};
          state   <= S_IDLE;
        end
        S_ROW0: state <= S_ROW1;
        S_ROW1: begin
          row_s <= rs_q;
          state <= S_ROW2;
        end
        S_ROW2: begin
          row_e <= rs_q;
          row_j <= row_s;
          state <= S_ENT0;
        end
        S_ENT0: state <= S_ENT1;
        S_ENT1: begin
          if (col_bad) begin
            bad <= 1'b1;
            row_j <= row_j + 1'b1;
            state <= S_ENT0;
          end else begin
            res_addr <= tgt_addr;
            state    <= S_ENT2;
          end
        end
        S_ENT2: state <= S_ENT3;
        S_ENT3: state <= S_ENT4;
        S_ENT4: begin
          row_j <= row_j + 1'b1;
          state <= S_ENT0;
        end
        default: state <= S_IDLE;
      endcase

      if (row_done) begin
        if (32'(row_i) + 32'd1 < rows_lim) begin
          row_i <= row_i + 1'b1;
          state <= S_ROW0;
        end else if (32'(o_cnt) + 32'd1 < n_lim) begin
          o_cnt  <= o_cnt + 1'b1;
          o_base <= o_base + ST_W'(MAX_DIM);
          row_i  <= '0;
          state  <= S_ROW0;
        end else begin
          o_valid <= 1'b1;
          o_item  <= '{status: (bad || (state == S_ENT1 && col_bad)) ? STATUS_RANGE
                                                                      : STATUS_OK,
                       result_re: '0, result_im: '0, saturated: 1'b0};
          state   <= S_IDLE;
        end
      end
    end
  end
endmodule

>>> bench/tb_csr_sparse_dense_multiply.sv
// Self-checking testbench for csr_sparse_dense_multiply: loads, compute in every op mode, reads.
// Needs csd_pkg, csd_stream_if, csd_mac and the DUT from the RTL; predicts each result and compares it in order.
`timescale 1ns / 1ps

module tb_csr_sparse_dense_multiply;
  import csd_pkg::*;

  localparam int DIM = DEF_MAX_DIM;
  localparam int NNZ = DEF_MAX_NNZ;
  localparam int RHS = DEF_MAX_RHS_COLS;
  localparam int FRAC = DEF_FRAC_BITS;
  localparam int DEPTH = DIM * RHS;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam int CYCLE_LIMIT = 6000000;
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    req_item_t item;
    bit        typed;
    rsp_item_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  csd_stream_if #(.item_t(req_item_t)) req_ch ();
  csd_stream_if #(.item_t(rsp_item_t)) rsp_ch ();

  csr_sparse_dense_multiply dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  // predicted block state
  logic [1:0] mode_q;
  int unsigned rows_q, cols_q, rhs_q;
  logic [10:0] row_ptr[DIM+1];
  bit row_ptr_set[DIM+1];
  logic [7:0] ent_col[NNZ];
  logic signed [15:0] ent_re[NNZ], ent_im[NNZ];
  bit ent_set[NNZ];
  logic signed [15:0] den_re[DEPTH], den_im[DEPTH];
  bit den_set[DEPTH];
  longint prod_re[DEPTH], prod_im[DEPTH];

  rsp_item_t pending_results[$];
  stim_row_t directed_rows[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_csr_sparse_dense_multiply: done, errors");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.item = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.item.status !== want.status)
          report("status", rsp_ch.item.status, want.status);
        if (rsp_ch.item.result_re !== want.result_re)
          report("result_re", rsp_ch.item.result_re, want.result_re);
        if (rsp_ch.item.result_im !== want.result_im)
          report("result_im", rsp_ch.item.result_im, want.result_im);
        if (rsp_ch.item.saturated !== want.saturated)
          report("saturated", rsp_ch.item.saturated, want.saturated);
      end
    end
  end

  function automatic longint sat40(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic void accumulate(int dst, int e, int d, bit conj);
    longint ar, ai, br, bi;
    ar = ent_re[e];
    ai = conj ? -longint'(ent_im[e]) : longint'(ent_im[e]);
    br = den_re[d];
    bi = den_im[d];
    prod_re[dst] = sat40(prod_re[dst], (ar * br - ai * bi) >>> FRAC);
    prod_im[dst] = sat40(prod_im[dst], (ar * bi + ai * br) >>> FRAC);
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    return v > hi ? hi : v;
  endfunction

  function automatic logic [1:0] multiply_all();
    int unsigned nr, nc, nb, s, e, c;
    logic [1:0] st;
    nr = clamp(rows_q, DIM);
    nc = clamp(cols_q, DIM);
    nb = clamp(rhs_q, RHS);
    st = STATUS_OK;
    for (int k = 0; k < DEPTH; k++) begin
      prod_re[k] = 0;
      prod_im[k] = 0;
    end
    for (int o = 0; o < nb; o++)
      for (int i = 0; i < nr; i++) begin
        s = clamp(row_ptr[i], NNZ);
        e = clamp(row_ptr[i+1], NNZ);
        for (int j = s; j < e; j++) begin
          c = ent_col[j];
          if (c >= nc) st = STATUS_RANGE;
          else if (mode_q != OP_PLAIN)
            accumulate(o * DIM + c, j, o * DIM + i, mode_q == OP_CONJ);
          else
            accumulate(o * DIM + i, j, o * DIM + c, 1'b0);
        end
      end
    return st;
  endfunction

  function automatic longint clip32(longint v, ref logic flag);
    if (v > 64'sd2147483647) begin flag = 1'b1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin flag = 1'b1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic rsp_item_t apply_command(req_item_t it);
    rsp_item_t r;
    int idx;
    logic flag;
    r = '0;
    flag = 1'b0;
    idx = int'(it.column) * DIM + int'(it.slot);
    case (it.command)
      CMD_ROW_START: begin
        if (it.slot > DIM || it.pointer_value > NNZ) r.status = STATUS_RANGE;
        else begin
          row_ptr[it.slot] = it.pointer_value;
          row_ptr_set[it.slot] = 1'b1;
        end
      end
      CMD_ENTRY: begin
        ent_col[it.slot] = it.column;
        ent_re[it.slot] = it.value_re;
        ent_im[it.slot] = it.value_im;
        ent_set[it.slot] = 1'b1;
      end
      CMD_DENSE: begin
        if (it.slot >= DIM || it.column >= RHS) r.status = STATUS_RANGE;
        else begin
          den_re[idx] = it.value_re;
          den_im[idx] = it.value_im;
          den_set[idx] = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        if (mode_q == OP_INVALID) r.status = STATUS_MODE;
        else r.status = multiply_all();
      end
      CMD_READ: begin
        if (it.slot >= DIM || it.column >= RHS) r.status = STATUS_RANGE;
        else begin
          r.result_re = 32'(clip32(prod_re[idx], flag));
          r.result_im = 32'(clip32(prod_im[idx], flag));
          r.saturated = flag;
        end
      end
      default: r.status = STATUS_RANGE;
    endcase
    return r;
  endfunction

  task automatic send(req_item_t it, bit typed = 1'b0, rsp_item_t exp = '0);
    rsp_item_t p;
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(0, 99) < send_idle_pct && gap < 12) gap++;
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.item <= it;
    do @(posedge clk); while (!req_ch.ready);
    p = apply_command(it);
    pending_results.push_back(typed ? exp : p);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OP_MODE: mode_q = value[1:0];
      REG_MATRIX_ROWS: rows_q = value & 9'h1FF;
      REG_MATRIX_COLS: cols_q = value & 9'h1FF;
      default: rhs_q = value & 4'hF;
    endcase
  endtask

  task automatic set_config(int unsigned op, int unsigned r, int unsigned c, int unsigned n);
    drain();
    write_reg(REG_OP_MODE, op);
    write_reg(REG_MATRIX_ROWS, r);
    write_reg(REG_MATRIX_COLS, c);
    write_reg(REG_RHS_COLS, n);
  endtask

  function automatic req_item_t make(logic [2:0] cmd, int unsigned slot, int unsigned ptr,
                                     int unsigned col, int re, int im);
    req_item_t it;
    it.command = cmd;
    it.slot = 10'(slot);
    it.pointer_value = 11'(ptr);
    it.column = 8'(col);
    it.value_re = 16'(re);
    it.value_im = 16'(im);
    return it;
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  // write every location the next compute will read that has not been written yet
  task automatic prepare_compute();
    int unsigned nr, nc, nb, s, e, c, d;
    nr = clamp(rows_q, DIM);
    nc = clamp(cols_q, DIM);
    nb = clamp(rhs_q, RHS);
    for (int i = 0; i <= nr && nr > 0 && nb > 0; i++)
      if (!row_ptr_set[i]) send(make(CMD_ROW_START, i, $urandom_range(0, 24), 0, 0, 0));
    for (int i = 0; i < nr && nb > 0; i++) begin
      s = clamp(row_ptr[i], NNZ);
      e = clamp(row_ptr[i+1], NNZ);
      for (int j = s; j < e; j++)
        if (!ent_set[j])
          send(make(CMD_ENTRY, j, 0, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
                    $urandom_range(0, nc > 0 ? nc - 1 : 0), rnd16(), rnd16()));
    end
    for (int o = 0; o < nb; o++)
      for (int i = 0; i < nr; i++) begin
        s = clamp(row_ptr[i], NNZ);
        e = clamp(row_ptr[i+1], NNZ);
        for (int j = s; j < e; j++) begin
          c = ent_col[j];
          if (c < nc) begin
            d = (mode_q != OP_PLAIN) ? i : c;
            if (!den_set[o * DIM + d]) send(make(CMD_DENSE, d, 0, o, rnd16(), rnd16()));
          end
        end
      end
  endtask

  task automatic compute_and_read(int reads);
    prepare_compute();
    send(make(CMD_COMPUTE, $urandom_range(0, 1023), $urandom_range(0, 2047),
              $urandom_range(0, 255), rnd16(), rnd16()));
    repeat (reads)
      send(make(CMD_READ, $urandom_range(0, 3), 0, $urandom_range(0, RHS - 1), 0, 0));
  endtask

  task automatic random_item();
    int pick;
    req_item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      compute_and_read(2);
      return;
    end
    it = make(CMD_READ, $urandom_range(0, 7), 0, $urandom_range(0, RHS - 1), rnd16(), rnd16());
    if (pick < 26) begin
      it.command = CMD_ENTRY;
      it.slot = 10'($urandom_range(0, 4) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 31));
      it.column = 8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7));
    end else if (pick < 38) begin
      it.command = CMD_ROW_START;
      it.slot = 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, DIM) : $urandom_range(0, 8));
      it.pointer_value = 11'($urandom_range(0, 24));
    end else if (pick < 56) begin
      it.command = CMD_DENSE;
      it.slot = 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, DIM - 1)
                                              : $urandom_range(0, 15));
    end else if (pick < 86) begin
      it.slot = 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, DIM - 1)
                                              : $urandom_range(0, 15));
    end else begin
      // out-of-range fields and spare commands; never writes anything
      it = make(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, rnd16(), rnd16());
      if (it.command == CMD_ROW_START && it.slot <= DIM) it.pointer_value[10] = 1'b1;
      if (it.command == CMD_ROW_START && it.pointer_value >= 11'd1024) it.pointer_value = 11'h7FF;
      if (it.command == CMD_ENTRY || it.command == CMD_COMPUTE) it.command = CMD_SPARE_6;
      if (it.command == CMD_DENSE || it.command == CMD_READ) it.slot[9] = 1'b1;
    end
    send(it);
  endtask

  function automatic rsp_item_t status_only(logic [1:0] st);
    rsp_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(req_item_t it, bit typed = 1'b0, logic [1:0] st = STATUS_OK);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.exp = status_only(st);
    directed_rows.push_back(row);
  endtask

  initial begin
    int unsigned op_set[8], rows_set[8], cols_set[8], rhs_set[8];
    int idle_set[4], stall_set[4];
    mode_q = OP_PLAIN;
    rows_q = 1;
    cols_q = 1;
    rhs_q = 1;
    for (int k = 0; k < DEPTH; k++) begin
      prod_re[k] = 0;
      prod_im[k] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(make(CMD_READ, 0, 0, 0, 0, 0), 1'b1, STATUS_OK);
    add_row(make(CMD_READ, DIM, 0, 0, 0, 0), 1'b1, STATUS_RANGE);
    add_row(make(CMD_READ, 0, 0, RHS, 0, 0), 1'b1, STATUS_RANGE);
    add_row(make(CMD_ROW_START, DIM + 1, 0, 0, 0, 0), 1'b1, STATUS_RANGE);
    add_row(make(CMD_ROW_START, 0, NNZ + 1, 0, 0, 0), 1'b1, STATUS_RANGE);
    add_row(make(CMD_ROW_START, DIM, NNZ, 0, 0, 0), 1'b1, STATUS_OK);
    add_row(make(CMD_ROW_START, DIM, 2, 0, 0, 0), 1'b1, STATUS_OK);
    add_row(make(CMD_ROW_START, 0, 0, 0, 0, 0), 1'b1, STATUS_OK);
    add_row(make(CMD_ROW_START, 1, 2, 0, 0, 0), 1'b1, STATUS_OK);
    add_row(make(CMD_ENTRY, 1023, 0, 255, -32768, 32767), 1'b1, STATUS_OK);
    add_row(make(CMD_ENTRY, 0, 0, 0, 32767, -32768), 1'b1, STATUS_OK);
    add_row(make(CMD_ENTRY, 1, 0, 0, -32768, -32768), 1'b1, STATUS_OK);
    add_row(make(CMD_DENSE, 0, 0, 0, -32768, -32768), 1'b1, STATUS_OK);
    add_row(make(CMD_DENSE, 1023, 0, 255, 32767, 32767), 1'b1, STATUS_RANGE);
    add_row(make(CMD_COMPUTE, 0, 0, 0, 0, 0));
    add_row(make(CMD_READ, 0, 0, 0, 0, 0));
    add_row(make(CMD_SPARE_5, 1023, 2047, 255, 32767, -1), 1'b1, STATUS_RANGE);
    add_row(make(CMD_SPARE_6, 0, 0, 0, 0, 0), 1'b1, STATUS_RANGE);
    add_row(make(CMD_SPARE_7, 1023, 2047, 255, -32768, 0), 1'b1, STATUS_RANGE);
    foreach (directed_rows[k])
      send(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].exp);

    for (int m = OP_PLAIN; m <= OP_INVALID; m++) begin
      set_config(m, 2, 4, 2);
      compute_and_read(3);
    end

    op_set = '{OP_PLAIN, OP_CONJ, OP_TRANS, OP_INVALID, OP_PLAIN, OP_TRANS, OP_CONJ, OP_PLAIN};
    rows_set = '{1, 24, 0, 4, 511, 8, 3, 6};
    cols_set = '{1, 256, 511, 8, 0, 5, 255, 6};
    rhs_set = '{1, 8, 15, 2, 0, 3, 4, 8};
    idle_set = '{0, 58, 0, 22};
    stall_set = '{0, 0, 58, 22};
    for (int ph = 0; ph < 8; ph++) begin
      set_config(op_set[ph], rows_set[ph], cols_set[ph], rhs_set[ph]);
      send_idle_pct = idle_set[ph % 4];
      stall_pct = stall_set[ph % 4];
      for (int k = 0; k < 70; k++) begin
        if (ph == 4 && k == 10) hold_request = 400;
        random_item();
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
    compute_and_read(4);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_csr_sparse_dense_multiply: done, clean");
    end else begin
      $display("tb_csr_sparse_dense_multiply: done, errors");
    end
    $finish;
  end

endmodule
